// File: sv/button_debounce_hold_repeat_macros.svh
// assertion macros shared by the button debounce block
// expects a clk and an active-low rst_n in the using scope
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BDHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bdhr_pkg.sv
// types and constants for the button debounce / hold / repeat block
// no dependencies
`timescale 1ns / 1ps

package bdhr_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_IS_PRESS  = 8'd0,
    REG_DEBOUNCE_TIME = 8'd1,
    REG_HOLD_TIME     = 8'd2,
    REG_STEP_INTERVAL = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             low_is_press;
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] step_interval;
  } bdhr_cfg_t;

  typedef struct packed {
    logic              last_raw;
    logic              stable_level;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] last_step_time;
    logic              hold_seen;
    logic              click_pending;
    logic              hold_pending;
    logic              step_pending;
  } bdhr_state_t;

  typedef struct packed {
    logic pressed;
    logic click_flag;
    logic hold_flag;
    logic step_flag;
  } bdhr_result_t;

  localparam bdhr_cfg_t CFG_RESET = '{
    low_is_press:  1'b1,
    debounce_time: 16'd20,
    hold_time:     16'd800,
    step_interval: 16'd150
  };

  localparam bdhr_state_t STATE_RESET = '0;

endpackage

// File: sv/bdhr_if.sv
// request channels of the button debounce block: input, result and register write
// depends on bdhr_pkg
`timescale 1ns / 1ps

interface bdhr_in_if;
  import bdhr_pkg::*;
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TIME_W-1:0] now_time;
  logic              take_click;
  logic              take_hold;
  logic              take_step;
  modport source (output valid, pin_level, now_time, take_click, take_hold, take_step,
                  input ready);
  modport sink (input valid, pin_level, now_time, take_click, take_hold, take_step,
                output ready);
endinterface

interface bdhr_out_if;
  logic valid;
  logic ready;
  logic pressed;
  logic click_flag;
  logic hold_flag;
  logic step_flag;
  modport source (output valid, pressed, click_flag, hold_flag, step_flag, input ready);
  modport sink (input valid, pressed, click_flag, hold_flag, step_flag, output ready);
endinterface

interface bdhr_cfg_if;
  import bdhr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/bdhr_cfg_regs.sv
// configuration register file: decodes register writes into the config struct
// depends on bdhr_pkg
`timescale 1ns / 1ps

module bdhr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bdhr_pkg::CFG_W-1:0]      wr_data,
  output bdhr_pkg::bdhr_cfg_t             cfg
);
  import bdhr_pkg::*;

  bdhr_cfg_t cfg_r;
  bdhr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_LOW_IS_PRESS:  cfg_nxt.low_is_press  = wr_data[0];
        REG_DEBOUNCE_TIME: cfg_nxt.debounce_time = wr_data;
        REG_HOLD_TIME:     cfg_nxt.hold_time     = wr_data;
        REG_STEP_INTERVAL: cfg_nxt.step_interval = wr_data;
        default:           cfg_nxt = cfg_r;  // unknown index is dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/bdhr_update.sv
// next-state and result logic for one sample: debounce, click, hold and repeat
// depends on bdhr_pkg
`timescale 1ns / 1ps

module bdhr_update (
  input  bdhr_pkg::bdhr_cfg_t            cfg,
  input  bdhr_pkg::bdhr_state_t          cur,
  input  logic                           pin_level,
  input  logic [bdhr_pkg::TIME_W-1:0]    now_time,
  input  logic                           take_click,
  input  logic                           take_hold,
  input  logic                           take_step,
  output bdhr_pkg::bdhr_state_t          nxt,
  output bdhr_pkg::bdhr_result_t         res
);
  import bdhr_pkg::*;

  logic              logical;
  logic              changed;
  logic [TIME_W-1:0] chg_age;
  logic [TIME_W-1:0] press_age;
  logic [TIME_W-1:0] step_age;
  logic              settle;
  logic              rise;
  logic              fall;
  logic              stable_n;
  logic              seen0;
  logic              hold_hit;
  logic              seen_n;
  logic              step_hit;
  logic              click_n;
  logic              holdp_n;
  logic              stepp_n;

  // the three ages come straight from registers; a timestamp just
  // restarted by this sample has age zero, so no compare waits on another
  always_comb begin
    logical   = pin_level ^ cfg.low_is_press;
    changed   = logical != cur.last_raw;
    chg_age   = now_time - cur.change_time;
    press_age = now_time - cur.press_time;
    step_age  = now_time - cur.last_step_time;

    settle    = (changed ? (cfg.debounce_time == '0)
                         : (chg_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time}))
                && (cur.stable_level != logical);
    rise      = settle && logical;
    fall      = settle && !logical;
    stable_n  = settle ? logical : cur.stable_level;

    seen0     = rise ? 1'b0 : cur.hold_seen;
    hold_hit  = stable_n && !seen0
                && (rise ? (cfg.hold_time == '0)
                         : (press_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time}));
    seen_n    = seen0 | hold_hit;

    step_hit  = stable_n && seen_n
                && ((rise || hold_hit) ? (cfg.step_interval == '0)
                    : (step_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.step_interval}));

    click_n   = cur.click_pending | (fall && !cur.hold_seen);
    holdp_n   = cur.hold_pending | hold_hit;
    stepp_n   = cur.step_pending | step_hit;

    res.pressed    = stable_n;
    res.click_flag = click_n;
    res.hold_flag  = holdp_n;
    res.step_flag  = stepp_n;

    nxt.last_raw       = logical;
    nxt.stable_level   = stable_n;
    nxt.change_time    = changed ? now_time : cur.change_time;
    nxt.press_time     = rise ? now_time : cur.press_time;
    nxt.last_step_time = (rise || hold_hit || step_hit) ? now_time : cur.last_step_time;
    nxt.hold_seen      = seen_n;
    nxt.click_pending  = click_n & ~take_click;
    nxt.hold_pending   = holdp_n & ~take_hold;
    nxt.step_pending   = stepp_n & ~take_step;
  end

endmodule

// File: sv/button_debounce_hold_repeat.sv
// Button debouncer with click, long-press hold and auto-repeat step events.
// Channels: in_ch brings one pin sample with its millisecond timestamp and
// three take bits; out_ch returns pressed plus the click, hold and step flags
// as they stand after that sample, before the take bits clear anything.
// cfg_ch writes low_is_press, debounce_time, hold_time and step_interval by
// index 0..3; other indexes are ignored. cfg_ch is always ready.
// Path: an accepted request waits in the input register and is processed
// into the output register as soon as out_ch has room for its result.
// Throughput: one request per cycle unless out_ch stalls. The state update is
// a single pass of three parallel 32-bit subtract/compares from state registers.
// An input register and an output register separate the two sides; while
// out_ch stalls, one more request is held in the input register, then
// in_ch.ready drops until the result is taken.
// Reset: the button starts released, no flags pending, registers at
// low_is_press=1, debounce 20 ms, hold 800 ms, step 150 ms.
// Depends on bdhr_pkg, bdhr_if, bdhr_cfg_regs, bdhr_update and the macro header.
`timescale 1ns / 1ps
`include "button_debounce_hold_repeat_macros.svh"

module button_debounce_hold_repeat (
  input logic       clk,
  input logic       rst_n,
  bdhr_in_if.sink   in_ch,
  bdhr_out_if.source out_ch,
  bdhr_cfg_if.sink  cfg_ch
);
  import bdhr_pkg::*;

  bdhr_cfg_t    cfg;
  bdhr_state_t  st_r;
  bdhr_state_t  st_nxt;
  bdhr_result_t res;

  // input register
  logic              in_v_r;
  logic              pin_r;
  logic [TIME_W-1:0] now_r;
  logic              take_click_r;
  logic              take_hold_r;
  logic              take_step_r;

  // output register
  logic         out_v_r;
  bdhr_result_t out_r;

  logic advance;
  logic in_take;

  assign advance = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  bdhr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  bdhr_update u_update (
    .cfg        (cfg),
    .cur        (st_r),
    .pin_level  (pin_r),
    .now_time   (now_r),
    .take_click (take_click_r),
    .take_hold  (take_hold_r),
    .take_step  (take_step_r),
    .nxt        (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pin_r        <= in_ch.pin_level;
      now_r        <= in_ch.now_time;
      take_click_r <= in_ch.take_click;
      take_hold_r  <= in_ch.take_hold;
      take_step_r  <= in_ch.take_step;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.pressed    = out_r.pressed;
  assign out_ch.click_flag = out_r.click_flag;
  assign out_ch.hold_flag  = out_r.hold_flag;
  assign out_ch.step_flag  = out_r.step_flag;

  // a fresh press restarts both the hold and the repeat timebase together
  `BDHR_ASSERT_NOW(a_press_aligns_timers, $rose(st_r.stable_level), st_r.press_time == st_r.last_step_time, "press and step timestamps differ on press")
  // the state only moves when a request is processed
  `BDHR_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(st_r), "state changed without a request")
  // a processed request always lands in the output register
  `BDHR_ASSERT_NEXT(a_result_follows, advance, out_v_r, "processed request left no result")
  // input side only backs up when the input register is occupied
  `BDHR_ASSERT_NOW(a_ready_drop_full, !in_ch.ready, in_v_r && out_v_r, "ready low with room to accept")

endmodule

// File: verif/bdhr_event_checker.sv
// checker for the button debounce block: watches the three request channels,
// predicts pressed/click/hold/step per sample and compares each result
// depends on bdhr_pkg and bdhr_if
`timescale 1ns / 1ps

module bdhr_event_checker
  import bdhr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bdhr_in_if   in_mon,
  bdhr_out_if  out_mon,
  bdhr_cfg_if  cfg_mon,
  output int   n_pending,
  output int   n_errors,
  output int   n_clicks,
  output int   n_holds,
  output int   n_steps
);

  bdhr_state_t  btn;
  bdhr_cfg_t    regs;
  bdhr_result_t expected_flags[$];
  int           err_cnt = 0;
  int           result_idx = 0;
  int           click_cnt = 0;
  int           hold_cnt = 0;
  int           step_cnt = 0;

  initial begin
    n_pending = 0;
    n_errors  = 0;
    n_clicks  = 0;
    n_holds   = 0;
    n_steps   = 0;
  end

  function automatic bdhr_result_t advance_button(input logic pin,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic clr_click, input logic clr_hold,
                                                  input logic clr_step);
    logic              level;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_step;
    bdhr_result_t      r;
    level = regs.low_is_press ? ~pin : pin;
    if (level != btn.last_raw) begin
      btn.last_raw    = level;
      btn.change_time = now;
    end
    since_change = now - btn.change_time;
    if (since_change >= TIME_W'(regs.debounce_time) && btn.stable_level != btn.last_raw) begin
      btn.stable_level = btn.last_raw;
      if (btn.stable_level) begin
        btn.press_time     = now;
        btn.last_step_time = now;
        btn.hold_seen      = 1'b0;
      end else if (!btn.hold_seen) begin
        btn.click_pending = 1'b1;
      end
    end
    if (btn.stable_level) begin
      since_press = now - btn.press_time;
      if (!btn.hold_seen && since_press >= TIME_W'(regs.hold_time)) begin
        btn.hold_seen      = 1'b1;
        btn.hold_pending   = 1'b1;
        btn.last_step_time = now;
      end
      // step timer restarts at the hold, so a zero interval also steps on that sample
      since_step = now - btn.last_step_time;
      if (btn.hold_seen && since_step >= TIME_W'(regs.step_interval)) begin
        btn.step_pending   = 1'b1;
        btn.last_step_time = now;
      end
    end
    r.pressed    = btn.stable_level;
    r.click_flag = btn.click_pending;
    r.hold_flag  = btn.hold_pending;
    r.step_flag  = btn.step_pending;
    if (clr_click) btn.click_pending = 1'b0;
    if (clr_hold) btn.hold_pending = 1'b0;
    if (clr_step) btn.step_pending = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bdhr_result_t got;
    bdhr_result_t want;
    if (!rst_n) begin
      btn  = STATE_RESET;
      regs = CFG_RESET;
      expected_flags.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_LOW_IS_PRESS:  regs.low_is_press  = cfg_mon.data[0];
          REG_DEBOUNCE_TIME: regs.debounce_time = cfg_mon.data;
          REG_HOLD_TIME:     regs.hold_time     = cfg_mon.data;
          REG_STEP_INTERVAL: regs.step_interval = cfg_mon.data;
          default: ;
        endcase
      end
      // a result can never belong to a sample taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.pressed    = out_mon.pressed;
        got.click_flag = out_mon.click_flag;
        got.hold_flag  = out_mon.hold_flag;
        got.step_flag  = out_mon.step_flag;
        if (got.click_flag === 1'b1) click_cnt++;
        if (got.hold_flag === 1'b1) hold_cnt++;
        if (got.step_flag === 1'b1) step_cnt++;
        if (expected_flags.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"%0t: result %0d arrived with no sample pending: ",
                      "pressed=%b click=%b hold=%b step=%b"},
                     $realtime, result_idx, got.pressed, got.click_flag, got.hold_flag,
                     got.step_flag);
        end else begin
          want = expected_flags.pop_front();
          if (got.pressed !== want.pressed || got.click_flag !== want.click_flag ||
              got.hold_flag !== want.hold_flag || got.step_flag !== want.step_flag) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: result %0d mismatch: ",
                        "expected pressed=%b click=%b hold=%b step=%b, ",
                        "got pressed=%b click=%b hold=%b step=%b"},
                       $realtime, result_idx, want.pressed, want.click_flag, want.hold_flag,
                       want.step_flag, got.pressed, got.click_flag, got.hold_flag,
                       got.step_flag);
          end
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_flags.push_back(advance_button(in_mon.pin_level, in_mon.now_time,
                                                in_mon.take_click, in_mon.take_hold,
                                                in_mon.take_step));
    end
    n_pending <= expected_flags.size();
    n_errors  <= err_cnt;
    n_clicks  <= click_cnt;
    n_holds   <= hold_cnt;
    n_steps   <= step_cnt;
  end

endmodule

// File: verif/button_debounce_hold_repeat_tb.sv
// top of the button debounce testbench: clock, reset, register setup and
// pin/timestamp stimulus with bursty sender and stalling receiver
// depends on bdhr_pkg, bdhr_if, the block and bdhr_event_checker
`timescale 1ns / 1ps

module button_debounce_hold_repeat_tb;
  import bdhr_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  localparam int PHASE_ITEMS   = 160;
  localparam int LONG_HOLDOFF  = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;

  bdhr_in_if  in_ch();
  bdhr_out_if out_ch();
  bdhr_cfg_if cfg_ch();

  int n_pending;
  int n_errors;
  int n_clicks;
  int n_holds;
  int n_steps;

  button_debounce_hold_repeat uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bdhr_event_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .n_pending (n_pending),
    .n_errors  (n_errors),
    .n_clicks  (n_clicks),
    .n_holds   (n_holds),
    .n_steps   (n_steps)
  );

  always #5 clk = ~clk;

  // stimulus state
  bdhr_cfg_t         cur_cfg;
  logic [TIME_W-1:0] ms_now;
  int                items_sent = 0;
  int                burst_left = 0;
  int                take_pct = 50;
  int                n_settings = 0;
  int                stall_tickets = 0;

  // receiver state, owned by the ready process
  int stall_served = 0;
  int holdoff_left = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int rx_phase = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    logic rdy;
    if (stall_served != stall_tickets) begin
      stall_served = stall_tickets;
      holdoff_left = LONG_HOLDOFF;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(30, 300);
    end
    mode_left--;
    rx_phase++;
    if (holdoff_left != 0) begin
      holdoff_left--;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ((rx_phase % 7) > 2);
      endcase
    end
    out_ch.ready <= rdy;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without any request moving", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bdhr_cfg_t make_cfg(input logic al, input int db, input int ho,
                                         input int st);
    bdhr_cfg_t c;
    c.low_is_press  = al;
    c.debounce_time = CFG_W'(db);
    c.hold_time     = CFG_W'(ho);
    c.step_interval = CFG_W'(st);
    return c;
  endfunction

  function automatic bdhr_cfg_t pick_cfg(input int ph);
    case (ph)
      0:       return make_cfg(1'b1, 5, 60, 10);
      1:       return make_cfg(1'b0, 0, 0, 0);
      2:       return make_cfg(1'b1, 65535, 65535, 65535);
      3:       return make_cfg(1'b0, 3, 40, 0);
      4:       return make_cfg(1'b1, 0, 30, 65535);
      5:       return make_cfg(1'b0, 65535, 0, 7);
      default: return make_cfg(1'($urandom_range(0, 1)), $urandom_range(0, 40),
                               $urandom_range(0, 300), $urandom_range(0, 80));
    endcase
  endfunction

  function automatic logic pin_for(input logic down);
    return cur_cfg.low_is_press ? ~down : down;
  endfunction

  task automatic push_sample(input logic pin, input logic [TIME_W-1:0] t, input logic tc,
                             input logic th, input logic ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.pin_level  <= pin;
    in_ch.now_time   <= t;
    in_ch.take_click <= tc;
    in_ch.take_hold  <= th;
    in_ch.take_step  <= ts;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic sample_at(input logic pin, input int dt);
    ms_now = ms_now + TIME_W'(dt);
    push_sample(pin, ms_now, coin(take_pct), coin(take_pct), coin(take_pct));
  endtask

  // sender stops and waits until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic program_regs(input bdhr_cfg_t c);
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: begin
          // out-of-range index, must be ignored
          cfg_ch.index <= CFG_IDX_W'($urandom_range(int'(REG_STEP_INTERVAL) + 1, 255));
          cfg_ch.data  <= CFG_W'($urandom());
        end
        1: begin
          cfg_ch.index <= REG_LOW_IS_PRESS;
          cfg_ch.data  <= {{(CFG_W-1){1'b0}}, c.low_is_press};
        end
        2: begin
          cfg_ch.index <= REG_DEBOUNCE_TIME;
          cfg_ch.data  <= c.debounce_time;
        end
        3: begin
          cfg_ch.index <= REG_HOLD_TIME;
          cfg_ch.data  <= c.hold_time;
        end
        default: begin
          cfg_ch.index <= REG_STEP_INTERVAL;
          cfg_ch.data  <= c.step_interval;
        end
      endcase
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  // bounce, hold down for a while, bounce, stay released
  task automatic press_and_release();
    int db;
    int span;
    int elapsed;
    int dt_max;
    int d;
    db     = int'(cur_cfg.debounce_time);
    dt_max = 1 + (db + int'(cur_cfg.hold_time) + 3 * int'(cur_cfg.step_interval)) / 25;
    repeat ($urandom_range(0, 4)) sample_at(1'($urandom_range(0, 1)), $urandom_range(0, 2));
    if ($urandom_range(0, 5) == 0)
      span = $urandom_range(0, db);
    else
      span = $urandom_range(0, 50 * dt_max);
    elapsed = 0;
    while (elapsed <= span) begin
      d = $urandom_range(0, dt_max);
      sample_at(pin_for(1'b1), d);
      elapsed += (d == 0) ? 1 : d;
    end
    repeat ($urandom_range(0, 4)) sample_at(1'($urandom_range(0, 1)), $urandom_range(0, 2));
    dt_max  = 1 + db / 10;
    span    = $urandom_range(0, 2 * db + 5);
    elapsed = 0;
    while (elapsed <= span) begin
      d = $urandom_range(0, dt_max);
      sample_at(pin_for(1'b0), d);
      elapsed += (d == 0) ? 1 : d;
    end
  endtask

  // random level with a timestamp jump, a step back or a long skip ahead
  task automatic noise_sample();
    case ($urandom_range(0, 2))
      0:       ms_now = $urandom();
      1:       ms_now = ms_now - TIME_W'($urandom_range(1, 1000));
      default: ms_now = ms_now + TIME_W'($urandom_range(0, 70000));
    endcase
    push_sample(1'($urandom_range(0, 1)), ms_now, coin(take_pct), coin(take_pct),
                coin(take_pct));
  endtask

  initial begin
    int phase_start;
    int pick;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pin_level  = 1'b0;
    in_ch.now_time   = '0;
    in_ch.take_click = 1'b0;
    in_ch.take_hold  = 1'b0;
    in_ch.take_step  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    cur_cfg          = CFG_RESET;
    ms_now           = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: active low, 20 ms debounce, 800 ms hold, 150 ms step
    push_sample(1'b1, 32'd0, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd5, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd24, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd25, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd824, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd825, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd975, 1'b0, 1'b1, 1'b1);
    // release after a hold gives no click
    push_sample(1'b1, 32'd980, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 32'd1000, 1'b1, 1'b0, 1'b0);
    // short press gives a click, left pending for a while
    push_sample(1'b0, 32'd1010, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd1030, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 32'd1100, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 32'd1120, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 32'd1200, 1'b1, 1'b0, 1'b0);
    // debounce across the timestamp wrap, then time running backwards
    push_sample(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'h0000_0004, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    push_sample(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    drain();

    // zero debounce, hold and step with an active-high pin
    program_regs(make_cfg(1'b0, 0, 0, 0));
    push_sample(1'b1, 32'd7, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 32'd7, 1'b1, 1'b1, 1'b1);
    push_sample(1'b0, 32'd8, 1'b1, 1'b1, 1'b1);
    push_sample(1'b1, 32'd9, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 32'd9, 1'b1, 1'b1, 1'b1);
    ms_now = 32'd9;

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      drain();
      program_regs(pick_cfg(ph));
      take_pct = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(5, 80);
      // receiver holds off while the sender keeps offering samples
      if (ph == 0 || $urandom_range(0, 2) == 0) stall_tickets <= stall_tickets + 1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          press_and_release();
        else if (pick < 95)
          repeat ($urandom_range(1, 4)) noise_sample();
        else
          drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d pin samples under %0d register settings, wrap and zero/max times",
             items_sent, n_settings);
    $display("results carrying click %0d, hold %0d, step %0d; errors %0d",
             n_clicks, n_holds, n_steps, n_errors);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
